// ----- hdl/command_frame_deframer_macros.svh -----
// Assertion macros used by the checker file of the command frame deframer.
`ifndef COMMAND_FRAME_DEFRAMER_MACROS_SVH
`define COMMAND_FRAME_DEFRAMER_MACROS_SVH

// Same-cycle implication, switched off while the reset is applied.
`define CFD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("command_frame_deframer: check failed");

// Next-cycle implication with an explicit disable condition.
`define CFD_ASSERT_NEXT(label, clk, dis, ante, cons) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("command_frame_deframer: check failed");

`endif

// ----- hdl/cfd_pkg.sv -----
// Types, codes and reset values of the command frame deframer.
package cfd_pkg;

  // Bytes of the frame header: module, index and separator.
  localparam int unsigned HeaderBytes = 3;

  localparam logic [7:0] START_ONE_RESET = 8'd35;
  localparam logic [7:0] START_TWO_RESET = 8'd35;
  localparam logic [7:0] SEPARATOR_RESET = 8'd44;
  localparam logic [7:0] END_RESET       = 8'd10;
  localparam logic [7:0] QUOTE_RESET     = 8'd34;
  localparam logic [7:0] CMD_LIMIT_RESET = 8'd32;
  localparam logic [7:0] PAR_LIMIT_RESET = 8'd16;
  localparam logic [7:0] STR_LIMIT_RESET = 8'd64;

  localparam logic [2:0] FID_COMMAND = 3'd0;
  localparam logic [2:0] FID_STRING  = 3'd5;

  typedef enum logic [3:0] {
    PH_WAIT      = 4'd0,
    PH_START2    = 4'd1,
    PH_HEADER    = 4'd2,
    PH_COMMAND   = 4'd3,
    PH_PAR1      = 4'd4,
    PH_PAR2      = 4'd5,
    PH_PAR3      = 4'd6,
    PH_PAR4      = 4'd7,
    PH_STR_START = 4'd8,
    PH_STR_DATA  = 4'd9,
    PH_STR_END   = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    EV_HEADER    = 3'd0,
    EV_BYTE      = 3'd1,
    EV_FIELD_END = 3'd2,
    EV_FRAME_END = 3'd3,
    EV_ABORT     = 3'd4
  } event_t;

  typedef enum logic [2:0] {
    AB_BAD_START     = 3'd0,
    AB_BAD_SEPARATOR = 3'd1,
    AB_FIELD_LONG    = 3'd2,
    AB_STRING_LONG   = 3'd3,
    AB_BAD_STR_START = 3'd4,
    AB_BAD_STR_END   = 3'd5
  } cause_t;

  typedef enum logic [2:0] {
    CFG_START_ONE = 3'd0,
    CFG_START_TWO = 3'd1,
    CFG_SEPARATOR = 3'd2,
    CFG_END       = 3'd3,
    CFG_QUOTE     = 3'd4,
    CFG_CMD_LIMIT = 3'd5,
    CFG_PAR_LIMIT = 3'd6,
    CFG_STR_LIMIT = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    event_t     ev;
    logic [2:0] fid;
    logic [7:0] data;
    logic [7:0] idx;
    cause_t     cause;
  } cfd_result_t;

endpackage

// ----- hdl/command_frame_deframer.sv -----
// Command frame deframer: splits a received byte stream into framed command events.
//
// The block takes one received byte per clock on the in_valid/in_ready channel and
// follows the frame grammar: a two-byte start mark, a module byte, an index byte and
// a separator (announced by one header result), then a command field and up to four
// parameter fields whose bytes are passed on one by one, each closed by the separator
// (field end) or by the end byte (frame end), and after the fourth parameter an
// optional quoted string. Broken or over-long frames give an abort result with its
// cause and the hunt for the start mark begins again. Each byte causes at most one
// result, which is registered in the output stage before it is shown on the
// out_valid/out_ready channel. The sustained rate is one byte per clock: the phase
// logic settles the next state and the result combinationally, and results go into
// a two-entry output stage (a result register backed by a skid register), so in_ready
// drops only when both entries hold results that the downstream side has not yet
// taken. Bytes that cause no result are still held back while in_ready is low. The
// configuration registers are written through cfg_we, cfg_index and cfg_data and
// must only be changed while the block is idle.
module command_frame_deframer
  import cfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] event_res,
  output logic [2:0] field_id,
  output logic [7:0] data_byte,
  output logic [7:0] index_byte,
  output logic [2:0] abort_cause
);

  localparam logic [1:0] HdrModule = 2'd0;
  localparam logic [1:0] HdrIndex  = 2'(HeaderBytes - 2);

  // Configuration registers.
  logic [7:0] start_mark_one;
  logic [7:0] start_mark_two;
  logic [7:0] separator_byte;
  logic [7:0] end_byte;
  logic [7:0] quote_byte;
  logic [7:0] command_length_limit;
  logic [7:0] parameter_length_limit;
  logic [7:0] string_length_limit;

  // Frame state.
  phase_t     phase, phase_next;
  logic [1:0] header_count, header_count_next;
  logic [7:0] module_hold, module_hold_next;
  logic [7:0] index_hold, index_hold_next;
  logic [7:0] field_length, field_length_next;

  // Output stage.
  logic        out_full;
  logic        skid_full;
  cfd_result_t out_res;
  cfd_result_t skid_res;

  logic        accept;
  logic        pop;
  logic        push;
  logic        has_result;
  cfd_result_t res;

  logic [8:0] len;
  logic [7:0] field_limit;
  logic [3:0] phase_offset;
  logic [2:0] phase_fid;

  assign accept = in_valid && in_ready;
  assign pop    = out_full && out_ready;
  assign push   = accept && has_result;

  // The input side only stalls when the skid register is occupied.
  assign in_ready = !skid_full;

  // Length the current field would reach with this byte.
  assign len          = {1'b0, field_length} + 9'd1;
  assign field_limit  = (phase == PH_COMMAND) ? command_length_limit : parameter_length_limit;
  assign phase_offset = phase - PH_COMMAND;

  // Field that the current phase is collecting; header and hunt phases report the command.
  always_comb begin
    if (phase >= PH_COMMAND && phase <= PH_PAR4) begin
      phase_fid = phase_offset[2:0];
    end else if (phase >= PH_STR_START && phase <= PH_STR_END) begin
      phase_fid = FID_STRING;
    end else begin
      phase_fid = FID_COMMAND;
    end
  end

  // Next-state logic of the frame sequencer.
  always_comb begin
    phase_next        = phase;
    header_count_next = header_count;
    module_hold_next  = module_hold;
    index_hold_next   = index_hold;
    field_length_next = field_length;
    unique case (phase)
      PH_START2: begin
        header_count_next = 2'd0;
        if (rx_byte == start_mark_two) begin
          phase_next = PH_HEADER;
        end else begin
          phase_next        = PH_WAIT;
          field_length_next = 8'd0;
        end
      end
      PH_HEADER: begin
        if (header_count == HdrModule) begin
          module_hold_next  = rx_byte;
          header_count_next = header_count + 2'd1;
        end else if (header_count == HdrIndex) begin
          index_hold_next   = rx_byte;
          header_count_next = header_count + 2'd1;
        end else begin
          header_count_next = 2'd0;
          field_length_next = 8'd0;
          phase_next        = (rx_byte == separator_byte) ? PH_COMMAND : PH_WAIT;
        end
      end
      PH_COMMAND, PH_PAR1, PH_PAR2, PH_PAR3, PH_PAR4: begin
        if (rx_byte == end_byte) begin
          phase_next        = PH_WAIT;
          field_length_next = 8'd0;
        end else if (rx_byte == separator_byte) begin
          // The fourth parameter steps on into the string opening phase.
          phase_next        = phase_t'(phase + 4'd1);
          field_length_next = 8'd0;
        end else if (len >= {1'b0, field_limit}) begin
          phase_next        = PH_WAIT;
          header_count_next = 2'd0;
          field_length_next = 8'd0;
        end else begin
          field_length_next = len[7:0];
        end
      end
      PH_STR_START: begin
        if (rx_byte == quote_byte) begin
          phase_next        = PH_STR_DATA;
          field_length_next = 8'd0;
        end else if (rx_byte == end_byte) begin
          phase_next = PH_WAIT;
        end else begin
          phase_next        = PH_WAIT;
          header_count_next = 2'd0;
          field_length_next = 8'd0;
        end
      end
      PH_STR_DATA: begin
        if (rx_byte == quote_byte) begin
          phase_next = PH_STR_END;
        end else if (len > {1'b0, string_length_limit}) begin
          phase_next        = PH_WAIT;
          header_count_next = 2'd0;
          field_length_next = 8'd0;
        end else begin
          field_length_next = len[7:0];
        end
      end
      PH_STR_END: begin
        phase_next        = PH_WAIT;
        field_length_next = 8'd0;
        if (rx_byte != end_byte) begin
          header_count_next = 2'd0;
        end
      end
      default: begin
        // Hunting for the first start mark byte.
        phase_next        = (rx_byte == start_mark_one) ? PH_START2 : PH_WAIT;
        header_count_next = 2'd0;
      end
    endcase
  end

  // Result of the byte presented in this cycle.
  always_comb begin
    has_result = 1'b0;
    res.ev     = EV_BYTE;
    res.fid    = phase_fid;
    res.data   = 8'd0;
    res.idx    = 8'd0;
    res.cause  = AB_BAD_START;
    unique case (phase)
      PH_START2: begin
        if (rx_byte != start_mark_two) begin
          has_result = 1'b1;
          res.ev     = EV_ABORT;
          res.cause  = AB_BAD_START;
        end
      end
      PH_HEADER: begin
        if (header_count != HdrModule && header_count != HdrIndex) begin
          has_result = 1'b1;
          if (rx_byte == separator_byte) begin
            res.ev   = EV_HEADER;
            res.data = module_hold;
            res.idx  = index_hold;
          end else begin
            res.ev    = EV_ABORT;
            res.cause = AB_BAD_SEPARATOR;
          end
        end
      end
      PH_COMMAND, PH_PAR1, PH_PAR2, PH_PAR3, PH_PAR4: begin
        has_result = 1'b1;
        if (rx_byte == end_byte) begin
          res.ev = EV_FRAME_END;
        end else if (rx_byte == separator_byte) begin
          res.ev = EV_FIELD_END;
        end else if (len >= {1'b0, field_limit}) begin
          res.ev    = EV_ABORT;
          res.cause = AB_FIELD_LONG;
        end else begin
          res.data = rx_byte;
        end
      end
      PH_STR_START: begin
        if (rx_byte != quote_byte) begin
          has_result = 1'b1;
          if (rx_byte == end_byte) begin
            res.ev = EV_FRAME_END;
          end else begin
            res.ev    = EV_ABORT;
            res.cause = AB_BAD_STR_START;
          end
        end
      end
      PH_STR_DATA: begin
        has_result = 1'b1;
        if (rx_byte == quote_byte) begin
          res.ev = EV_FIELD_END;
        end else if (len > {1'b0, string_length_limit}) begin
          res.ev    = EV_ABORT;
          res.cause = AB_STRING_LONG;
        end else begin
          res.data = rx_byte;
        end
      end
      PH_STR_END: begin
        has_result = 1'b1;
        if (rx_byte == end_byte) begin
          res.ev = EV_FRAME_END;
        end else begin
          res.ev    = EV_ABORT;
          res.cause = AB_BAD_STR_END;
        end
      end
      default: begin
        has_result = 1'b0;
      end
    endcase
  end

  // Configuration, frame state and occupancy of the output stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      start_mark_one         <= START_ONE_RESET;
      start_mark_two         <= START_TWO_RESET;
      separator_byte         <= SEPARATOR_RESET;
      end_byte               <= END_RESET;
      quote_byte             <= QUOTE_RESET;
      command_length_limit   <= CMD_LIMIT_RESET;
      parameter_length_limit <= PAR_LIMIT_RESET;
      string_length_limit    <= STR_LIMIT_RESET;
      phase                  <= PH_WAIT;
      header_count           <= 2'd0;
      module_hold            <= 8'd0;
      index_hold             <= 8'd0;
      field_length           <= 8'd0;
      out_full               <= 1'b0;
      skid_full              <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_START_ONE: start_mark_one         <= cfg_data;
          CFG_START_TWO: start_mark_two         <= cfg_data;
          CFG_SEPARATOR: separator_byte         <= cfg_data;
          CFG_END:       end_byte               <= cfg_data;
          CFG_QUOTE:     quote_byte             <= cfg_data;
          CFG_CMD_LIMIT: command_length_limit   <= cfg_data;
          CFG_PAR_LIMIT: parameter_length_limit <= cfg_data;
          CFG_STR_LIMIT: string_length_limit    <= cfg_data;
        endcase
      end
      if (accept) begin
        phase        <= phase_next;
        header_count <= header_count_next;
        module_hold  <= module_hold_next;
        index_hold   <= index_hold_next;
        field_length <= field_length_next;
      end
      // While the skid register is full no request is accepted, so a pop simply
      // moves the skid entry forward.
      if (skid_full) begin
        if (pop) begin
          skid_full <= 1'b0;
        end
      end else if (push) begin
        if (out_full && !pop) begin
          skid_full <= 1'b1;
        end else begin
          out_full <= 1'b1;
        end
      end else if (pop) begin
        out_full <= 1'b0;
      end
    end
  end

  // Result payloads carry no reset.
  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (pop) begin
        out_res <= skid_res;
      end
    end else if (push) begin
      if (out_full && !pop) begin
        skid_res <= res;
      end else begin
        out_res <= res;
      end
    end
  end

  assign out_valid   = out_full;
  assign event_res   = out_res.ev;
  assign field_id    = out_res.fid;
  assign data_byte   = out_res.data;
  assign index_byte  = out_res.idx;
  assign abort_cause = out_res.cause;

endmodule

// ----- hdl/cfd_checker.sv -----
// Port-level assertion checker of the command frame deframer and its bind.
`include "command_frame_deframer_macros.svh"

module cfd_checker
  import cfd_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] event_res,
  input logic [2:0] field_id,
  input logic [7:0] data_byte,
  input logic [7:0] index_byte,
  input logic [2:0] abort_cause
);

  // A result that waits must keep its contents until it is taken.
  `CFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(event_res) && $stable(field_id) && $stable(data_byte) &&
    $stable(index_byte) && $stable(abort_cause))

  // Reset empties the output stage.
  `CFD_ASSERT_NEXT(a_reset_empty, clk, 1'b0, rst, !out_valid)

  // The input side only stalls while results are waiting to be taken.
  `CFD_ASSERT_IMPLY(a_stall_full, clk, rst, !in_ready, out_valid)

  // A header always belongs to the command slot and carries no cause.
  `CFD_ASSERT_IMPLY(a_header_fields, clk, rst, out_valid && event_res == EV_HEADER,
    field_id == FID_COMMAND && abort_cause == AB_BAD_START)

  // Only aborts carry a cause, and only headers carry an index byte.
  `CFD_ASSERT_IMPLY(a_cause_index, clk, rst,
    out_valid && event_res != EV_ABORT && event_res != EV_HEADER,
    abort_cause == AB_BAD_START && index_byte == 8'd0)

endmodule

bind command_frame_deframer cfd_checker u_cfd_checker (.*);
